### sv/ctc_pkg.sv
// shared types and constants for the 8-bit timer/counter with clear-on-compare
// no dependencies
package ctc_pkg;

  localparam int PRESCALE_BITS_DEF = 10;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // register addresses
  localparam logic [2:0] ADDR_CTRLA = 3'd0;
  localparam logic [2:0] ADDR_CTRLB = 3'd1;
  localparam logic [2:0] ADDR_MASK  = 3'd2;
  localparam logic [2:0] ADDR_FLAGS = 3'd3;
  localparam logic [2:0] ADDR_COUNT = 3'd4;
  localparam logic [2:0] ADDR_CMPA  = 3'd5;
  localparam logic [2:0] ADDR_CMPB  = 3'd6;

  // clock select codes
  localparam logic [2:0] CS_STOP  = 3'd0;
  localparam logic [2:0] CS_DIV1  = 3'd1;
  localparam logic [2:0] CS_DIV8  = 3'd2;
  localparam logic [2:0] CS_DIV64 = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;
  localparam logic [2:0] CS_EXT_FALL = 3'd6;
  localparam logic [2:0] CS_EXT_RISE = 3'd7;

  localparam logic [2:0] WGM_CTC = 3'b010;

  localparam logic [7:0] CTRLA_MASK = 8'hF3;
  localparam logic [7:0] CTRLB_MASK = 8'h0F;
  localparam logic [7:0] COUNT_TOP  = 8'hFF;

  // flag / enable bit positions
  localparam int FLAG_WRAP = 0;
  localparam int FLAG_MA   = 1;
  localparam int FLAG_MB   = 2;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] addr;
    logic [7:0] wdata;
    logic       pin;
  } item_t;

  typedef struct packed {
    logic [7:0] count_now;
    logic       irq_wrap;
    logic       irq_match_b;
    logic       irq_match_a;
    logic [7:0] read_data;
  } result_t;

  // request from the register core to the prescaler
  typedef struct packed {
    logic       tick;
    logic [2:0] cs;
    logic       pin;
  } tick_req_t;

endpackage

### sv/ctc_prescaler.sv
// tick-driven prescaler and external pin edge detect, gives the counter enable
// depends on ctc_pkg
module ctc_prescaler
  import ctc_pkg::*;
#(
  parameter int PRESCALE_BITS = PRESCALE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tick_req_t req,
  output logic      count_en
);

  logic [PRESCALE_BITS-1:0] pre_r, pre_nxt;
  logic                     pin_prev_r, pin_prev_nxt;

  assign pre_nxt      = req.tick ? pre_r + 1'b1 : pre_r;
  assign pin_prev_nxt = req.tick ? req.pin : pin_prev_r;

  always_comb begin
    count_en = 1'b0;
    case (req.cs)
      CS_STOP:     count_en = 1'b0;
      CS_DIV1:     count_en = 1'b1;
      CS_DIV8:     count_en = (pre_nxt[2:0] == '0);
      CS_DIV64:    count_en = (pre_nxt[5:0] == '0);
      CS_DIV256:   count_en = (pre_nxt[7:0] == '0);
      CS_DIV1024:  count_en = (pre_nxt[9:0] == '0);
      CS_EXT_FALL: count_en = pin_prev_r & ~req.pin;
      CS_EXT_RISE: count_en = ~pin_prev_r & req.pin;
      default:     count_en = 1'b0;
    endcase
    count_en = count_en & req.tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r      <= '0;
      pin_prev_r <= 1'b0;
    end else begin
      pre_r      <= pre_nxt;
      pin_prev_r <= pin_prev_nxt;
    end
  end

endmodule

### sv/ctc_core.sv
// bus registers, counter and flags; applies one item per enabled cycle
// depends on ctc_pkg
module ctc_core
  import ctc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  item_t     item,
  input  logic      count_en,
  output tick_req_t req,
  output result_t   result
);

  logic [7:0] ctrla_r, ctrla_nxt;
  logic [7:0] ctrlb_r, ctrlb_nxt;
  logic [2:0] en_r, en_nxt;
  logic [2:0] flags_r, flags_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] cmpa_r, cmpa_nxt;
  logic [7:0] cmpb_r, cmpb_nxt;
  logic [7:0] rdata;
  logic [2:0] wgm;
  logic [2:0] act;

  assign wgm      = {ctrlb_r[3], ctrla_r[1:0]};
  assign req.tick = step_en && (item.op == OP_TICK);
  assign req.cs   = ctrlb_r[2:0];
  assign req.pin  = item.pin;

  always_comb begin
    ctrla_nxt = ctrla_r;
    ctrlb_nxt = ctrlb_r;
    en_nxt    = en_r;
    flags_nxt = flags_r;
    count_nxt = count_r;
    cmpa_nxt  = cmpa_r;
    cmpb_nxt  = cmpb_r;
    rdata     = 8'h00;

    if (step_en && item.op == OP_TICK && count_en) begin
      if (count_r == cmpa_r)    flags_nxt[FLAG_MA]   = 1'b1;
      if (count_r == cmpb_r)    flags_nxt[FLAG_MB]   = 1'b1;
      if (count_r == COUNT_TOP) flags_nxt[FLAG_WRAP] = 1'b1;
      if (wgm == WGM_CTC && count_r == cmpa_r) count_nxt = 8'h00;
      else                                     count_nxt = count_r + 8'd1;
    end

    if (step_en && item.op == OP_READ) begin
      unique case (item.addr)
        ADDR_CTRLA: rdata = ctrla_r;
        ADDR_CTRLB: rdata = ctrlb_r;
        ADDR_MASK:  rdata = {5'b0, en_r};
        ADDR_FLAGS: rdata = {5'b0, flags_r};
        ADDR_COUNT: rdata = count_r;
        ADDR_CMPA:  rdata = cmpa_r;
        ADDR_CMPB:  rdata = cmpb_r;
        default:    rdata = 8'h00;
      endcase
    end

    if (step_en && item.op == OP_WRITE) begin
      unique case (item.addr)
        ADDR_CTRLA: ctrla_nxt = item.wdata & CTRLA_MASK;
        ADDR_CTRLB: ctrlb_nxt = item.wdata & CTRLB_MASK;
        ADDR_MASK:  en_nxt    = item.wdata[2:0];
        ADDR_FLAGS: flags_nxt = flags_r & ~item.wdata[2:0];
        ADDR_COUNT: count_nxt = item.wdata;
        ADDR_CMPA:  cmpa_nxt  = item.wdata;
        ADDR_CMPB:  cmpb_nxt  = item.wdata;
        default:    ;
      endcase
    end
  end

  assign act                = flags_nxt & en_nxt;
  assign result.read_data   = rdata;
  assign result.irq_match_a = act[FLAG_MA];
  assign result.irq_match_b = act[FLAG_MB];
  assign result.irq_wrap    = act[FLAG_WRAP];
  assign result.count_now   = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrla_r <= '0;
      ctrlb_r <= '0;
      en_r    <= '0;
      flags_r <= '0;
      count_r <= '0;
      cmpa_r  <= '0;
      cmpb_r  <= '0;
    end else begin
      ctrla_r <= ctrla_nxt;
      ctrlb_r <= ctrlb_nxt;
      en_r    <= en_nxt;
      flags_r <= flags_nxt;
      count_r <= count_nxt;
      cmpa_r  <= cmpa_nxt;
      cmpb_r  <= cmpb_nxt;
    end
  end

endmodule

### sv/timer_counter_8bit_ctc.sv
// top level of the 8-bit timer/counter with clear-on-compare
// depends on ctc_pkg, ctc_prescaler and ctc_core
//
// usage:
//   the input stream carries one item per transfer: a clock tick (with the
//   external pin level), a bus read or a bus write, selected by in_tuser.
//   every input transfer yields exactly one output transfer carrying the read
//   byte (zero unless a read), the three interrupt requests and the count.
//   each accepted item lands in an input register; once the output register is
//   free or draining, the core applies it to the timer state and the result is
//   captured in the output register, which raises out_tvalid.
//   throughput is one item per cycle while out_tready stays high: the input
//   register refills in the same cycle its item moves on, and the step itself
//   is three compares and one 8-bit increment in the counter update path.
//   when out_tready is low the output register holds its result, the input
//   register holds the next item, and in_tready drops only once both are full.
//   a synchronous low rst_n clears all bus registers, the prescaler, the pin
//   history and the valid flags of both stream stages.
module timer_counter_8bit_ctc
  import ctc_pkg::*;
#(
  parameter int PRESCALE_BITS = PRESCALE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] reg_address, [10:3] write_data, [11] ext_pin, [15:12] zero
  input  logic [15:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] irq_match_a, [9] irq_match_b, [10] irq_wrap,
  // [18:11] count_now, [23:19] zero
  output logic [23:0] out_tdata
);

  item_t     item_r;
  logic      in_valid_r;
  result_t   res_r;
  logic      out_valid_r;
  logic      advance;
  logic      count_en;
  tick_req_t req;
  result_t   result;

  // item moves into the core when the output register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ctc_prescaler #(
    .PRESCALE_BITS(PRESCALE_BITS)
  ) u_prescaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .count_en (count_en)
  );

  ctc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .item     (item_r),
    .count_en (count_en),
    .req      (req),
    .result   (result)
  );

  // stream stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op    <= in_tuser;
      item_r.addr  <= in_tdata[2:0];
      item_r.wdata <= in_tdata[10:3];
      item_r.pin   <= in_tdata[11];
    end
    if (advance) res_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.count_now, res_r.irq_wrap, res_r.irq_match_b,
                       res_r.irq_match_a, res_r.read_data};

endmodule
